[hw/rtl/qtrs_pkg.sv]
// qtrs_pkg: shared types, widths and arithmetic helpers for the quaternion TRS matrix pipeline.
// No dependencies. Used by every module in hw/rtl.
package qtrs_pkg;

   localparam int unsigned PosW   = 32;  // Q16.16
   localparam int unsigned QuatW  = 16;  // Q1.15
   localparam int unsigned ScaleW = 16;  // Q8.8
   localparam int unsigned ProdW  = 32;  // Q2.30 quaternion product
   localparam int unsigned TermW  = 34;  // Q2.30 rotation term, with headroom
   localparam int unsigned WideW  = 50;  // term times scale, Q.38
   localparam int unsigned FracDrop = 22;
   localparam int unsigned EntryW = 32;  // Q16.16 matrix entry

   localparam logic signed [TermW-1:0] OneQ230 = 34'sd1073741824;

   typedef struct packed {
      logic signed [PosW-1:0] x;
      logic signed [PosW-1:0] y;
      logic signed [PosW-1:0] z;
   } pos_type;

   typedef struct packed {
      logic signed [QuatW-1:0] w;
      logic signed [QuatW-1:0] x;
      logic signed [QuatW-1:0] y;
      logic signed [QuatW-1:0] z;
   } quat_type;

   typedef struct packed {
      logic signed [ScaleW-1:0] x;
      logic signed [ScaleW-1:0] y;
      logic signed [ScaleW-1:0] z;
   } scale_type;

   // request as taken from the input ports
   typedef struct packed {
      pos_type   pos;
      quat_type  quat;
      scale_type scale;
   } req_type;

   typedef struct packed {
      logic signed [ProdW-1:0] xx;
      logic signed [ProdW-1:0] yy;
      logic signed [ProdW-1:0] zz;
      logic signed [ProdW-1:0] xy;
      logic signed [ProdW-1:0] xz;
      logic signed [ProdW-1:0] yz;
      logic signed [ProdW-1:0] wx;
      logic signed [ProdW-1:0] wy;
      logic signed [ProdW-1:0] wz;
   } prod_type;

   typedef struct packed {
      pos_type   pos;
      scale_type scale;
      prod_type  prod;
   } stage1_type;

   typedef struct packed {
      logic signed [TermW-1:0] t00;
      logic signed [TermW-1:0] t01;
      logic signed [TermW-1:0] t02;
      logic signed [TermW-1:0] t10;
      logic signed [TermW-1:0] t11;
      logic signed [TermW-1:0] t12;
      logic signed [TermW-1:0] t20;
      logic signed [TermW-1:0] t21;
      logic signed [TermW-1:0] t22;
   } term_type;

   typedef struct packed {
      pos_type   pos;
      scale_type scale;
      term_type  term;
   } stage2_type;

   typedef struct packed {
      logic signed [WideW-1:0] p00;
      logic signed [WideW-1:0] p01;
      logic signed [WideW-1:0] p02;
      logic signed [WideW-1:0] p10;
      logic signed [WideW-1:0] p11;
      logic signed [WideW-1:0] p12;
      logic signed [WideW-1:0] p20;
      logic signed [WideW-1:0] p21;
      logic signed [WideW-1:0] p22;
   } wide_type;

   typedef struct packed {
      pos_type  pos;
      wide_type wide;
   } stage3_type;

   typedef struct packed {
      logic signed [EntryW-1:0] m00;
      logic signed [EntryW-1:0] m01;
      logic signed [EntryW-1:0] m02;
      logic signed [EntryW-1:0] m10;
      logic signed [EntryW-1:0] m11;
      logic signed [EntryW-1:0] m12;
      logic signed [EntryW-1:0] m20;
      logic signed [EntryW-1:0] m21;
      logic signed [EntryW-1:0] m22;
   } mat_type;

   typedef struct packed {
      pos_type pos;
      mat_type mat;
   } rsp_type;

   // Q1.15 x Q1.15 -> Q2.30, exact
   function automatic logic signed [ProdW-1:0] mul_q15(input logic signed [QuatW-1:0] a,
                                                       input logic signed [QuatW-1:0] b);
      logic signed [ProdW-1:0] ea;
      logic signed [ProdW-1:0] eb;
      ea = {{(ProdW-QuatW){a[QuatW-1]}}, a};
      eb = {{(ProdW-QuatW){b[QuatW-1]}}, b};
      return ea * eb;
   endfunction

   function automatic logic signed [TermW-1:0] ext_prod(input logic signed [ProdW-1:0] a);
      return {{(TermW-ProdW){a[ProdW-1]}}, a};
   endfunction

   // 1 - 2(a + b)
   function automatic logic signed [TermW-1:0] diag_term(input logic signed [ProdW-1:0] a,
                                                         input logic signed [ProdW-1:0] b);
      logic signed [TermW-1:0] s;
      s = ext_prod(a) + ext_prod(b);
      return OneQ230 - (s <<< 1);
   endfunction

   // 2(a + b)
   function automatic logic signed [TermW-1:0] sum_term(input logic signed [ProdW-1:0] a,
                                                        input logic signed [ProdW-1:0] b);
      logic signed [TermW-1:0] s;
      s = ext_prod(a) + ext_prod(b);
      return s <<< 1;
   endfunction

   // 2(a - b)
   function automatic logic signed [TermW-1:0] diff_term(input logic signed [ProdW-1:0] a,
                                                         input logic signed [ProdW-1:0] b);
      logic signed [TermW-1:0] s;
      s = ext_prod(a) - ext_prod(b);
      return s <<< 1;
   endfunction

   // Q2.30 term x Q8.8 scale -> Q.38, exact
   function automatic logic signed [WideW-1:0] mul_scale(input logic signed [TermW-1:0] t,
                                                         input logic signed [ScaleW-1:0] s);
      logic signed [WideW-1:0] et;
      logic signed [WideW-1:0] es;
      et = {{(WideW-TermW){t[TermW-1]}}, t};
      es = {{(WideW-ScaleW){s[ScaleW-1]}}, s};
      return et * es;
   endfunction

   // Drop 22 fraction bits rounding to minus infinity, then clamp to 32 bits.
   // |term| <= 2^32 and |scale| <= 2^15 keep the shifted value within 28 bits,
   // so the clamp reduces to a sign extension.
   function automatic logic signed [EntryW-1:0] to_entry(input logic signed [WideW-1:0] p);
      return {{(EntryW-(WideW-FracDrop)){p[WideW-1]}}, p[WideW-1:FracDrop]};
   endfunction

endpackage

[hw/rtl/qtrs_prod.sv]
// qtrs_prod: pipeline stage 1, the nine quaternion products in Q2.30.
// Depends on qtrs_pkg.
module qtrs_prod (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  qtrs_pkg::req_type    in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output qtrs_pkg::stage1_type out_data
);

   logic                 valid_ff;
   logic                 valid_in;
   qtrs_pkg::stage1_type data_ff;
   qtrs_pkg::stage1_type data_in;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_comb begin
      data_in.pos     = in_data.pos;
      data_in.scale   = in_data.scale;
      data_in.prod.xx = qtrs_pkg::mul_q15(in_data.quat.x, in_data.quat.x);
      data_in.prod.yy = qtrs_pkg::mul_q15(in_data.quat.y, in_data.quat.y);
      data_in.prod.zz = qtrs_pkg::mul_q15(in_data.quat.z, in_data.quat.z);
      data_in.prod.xy = qtrs_pkg::mul_q15(in_data.quat.x, in_data.quat.y);
      data_in.prod.xz = qtrs_pkg::mul_q15(in_data.quat.x, in_data.quat.z);
      data_in.prod.yz = qtrs_pkg::mul_q15(in_data.quat.y, in_data.quat.z);
      data_in.prod.wx = qtrs_pkg::mul_q15(in_data.quat.w, in_data.quat.x);
      data_in.prod.wy = qtrs_pkg::mul_q15(in_data.quat.w, in_data.quat.y);
      data_in.prod.wz = qtrs_pkg::mul_q15(in_data.quat.w, in_data.quat.z);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

[hw/rtl/qtrs_term.sv]
// qtrs_term: pipeline stage 2, rotation matrix terms in Q2.30 from the products.
// Depends on qtrs_pkg.
module qtrs_term (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  qtrs_pkg::stage1_type in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output qtrs_pkg::stage2_type out_data
);

   logic                 valid_ff;
   logic                 valid_in;
   qtrs_pkg::stage2_type data_ff;
   qtrs_pkg::stage2_type data_in;
   qtrs_pkg::prod_type   p;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;
   assign p        = in_data.prod;

   // column c, row r -> t<c><r>
   always_comb begin
      data_in.pos      = in_data.pos;
      data_in.scale    = in_data.scale;
      data_in.term.t00 = qtrs_pkg::diag_term(p.yy, p.zz);
      data_in.term.t01 = qtrs_pkg::sum_term(p.xy, p.wz);
      data_in.term.t02 = qtrs_pkg::diff_term(p.xz, p.wy);
      data_in.term.t10 = qtrs_pkg::diff_term(p.xy, p.wz);
      data_in.term.t11 = qtrs_pkg::diag_term(p.xx, p.zz);
      data_in.term.t12 = qtrs_pkg::sum_term(p.yz, p.wx);
      data_in.term.t20 = qtrs_pkg::sum_term(p.xz, p.wy);
      data_in.term.t21 = qtrs_pkg::diff_term(p.yz, p.wx);
      data_in.term.t22 = qtrs_pkg::diag_term(p.xx, p.yy);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

[hw/rtl/qtrs_scale.sv]
// qtrs_scale: pipeline stages 3 and 4, column scaling then truncation into the output register.
// Depends on qtrs_pkg.
module qtrs_scale (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  qtrs_pkg::stage2_type in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output qtrs_pkg::rsp_type    out_data
);

   // stage 3: term x scale
   logic                 mul_valid_ff;
   logic                 mul_valid_in;
   logic                 mul_ready;
   qtrs_pkg::stage3_type mul_data_ff;
   qtrs_pkg::stage3_type mul_data_in;
   qtrs_pkg::term_type   t;
   qtrs_pkg::scale_type  s;

   // stage 4: output register
   logic                 out_valid_ff;
   logic                 out_valid_in;
   qtrs_pkg::rsp_type    out_data_ff;
   qtrs_pkg::rsp_type    out_data_in;
   qtrs_pkg::wide_type   w;

   assign t = in_data.term;
   assign s = in_data.scale;

   assign mul_ready    = !out_valid_ff || out_ready;
   assign in_ready     = !mul_valid_ff || mul_ready;
   assign mul_valid_in = in_ready ? in_valid : mul_valid_ff;
   assign out_valid_in = mul_ready ? mul_valid_ff : out_valid_ff;

   always_comb begin
      mul_data_in.pos      = in_data.pos;
      mul_data_in.wide.p00 = qtrs_pkg::mul_scale(t.t00, s.x);
      mul_data_in.wide.p01 = qtrs_pkg::mul_scale(t.t01, s.x);
      mul_data_in.wide.p02 = qtrs_pkg::mul_scale(t.t02, s.x);
      mul_data_in.wide.p10 = qtrs_pkg::mul_scale(t.t10, s.y);
      mul_data_in.wide.p11 = qtrs_pkg::mul_scale(t.t11, s.y);
      mul_data_in.wide.p12 = qtrs_pkg::mul_scale(t.t12, s.y);
      mul_data_in.wide.p20 = qtrs_pkg::mul_scale(t.t20, s.z);
      mul_data_in.wide.p21 = qtrs_pkg::mul_scale(t.t21, s.z);
      mul_data_in.wide.p22 = qtrs_pkg::mul_scale(t.t22, s.z);
   end

   assign w = mul_data_ff.wide;

   always_comb begin
      out_data_in.pos     = mul_data_ff.pos;
      out_data_in.mat.m00 = qtrs_pkg::to_entry(w.p00);
      out_data_in.mat.m01 = qtrs_pkg::to_entry(w.p01);
      out_data_in.mat.m02 = qtrs_pkg::to_entry(w.p02);
      out_data_in.mat.m10 = qtrs_pkg::to_entry(w.p10);
      out_data_in.mat.m11 = qtrs_pkg::to_entry(w.p11);
      out_data_in.mat.m12 = qtrs_pkg::to_entry(w.p12);
      out_data_in.mat.m20 = qtrs_pkg::to_entry(w.p20);
      out_data_in.mat.m21 = qtrs_pkg::to_entry(w.p21);
      out_data_in.mat.m22 = qtrs_pkg::to_entry(w.p22);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         mul_valid_ff <= mul_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         mul_data_ff <= mul_data_in;
      end
      if (mul_valid_ff && mul_ready) begin
         out_data_ff <= out_data_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

endmodule

[hw/rtl/quaternion_trs_matrix_top.sv]
// quaternion_trs_matrix_top: builds the upper three rows of a 4x4 TRS transform.
// Depends on qtrs_pkg, qtrs_prod, qtrs_term and qtrs_scale.
//
// Usage
//   Request channel (req_*): translation Q16.16, rotation quaternion Q1.15 and
//   per-axis scale Q8.8, taken when req_valid and req_ready are both high.
//   Response channel (rsp_*): the 3x3 rotation-scale block (column c, row r
//   on rsp_m<c><r>) in Q16.16 and the translation passed through unchanged.
//   Quaternions are used as given; no normalisation.
//   Pipeline: four register stages, one each for the quaternion products, the
//   rotation terms, the scale multiplies and the output truncation. The first
//   is loaded at the accepting edge, and rsp_valid is the valid bit of the last.
//   Throughput: one request per cycle while nothing stalls; each stage holds
//   one request and moves on whenever the stage after it is empty or draining.
//   Stall: with rsp_ready low the pipeline fills up behind the output
//   register; req_ready drops only once all four stages hold a request,
//   and nothing is lost or repeated.
//   Reset: synchronous, active high; clears every stage valid bit and the
//   in-flight count, so any requests in flight are discarded. Data is not reset.
module quaternion_trs_matrix_top (
   input  logic               clock,
   input  logic               reset,

   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   input  logic signed [15:0] req_quat_w,
   input  logic signed [15:0] req_quat_x,
   input  logic signed [15:0] req_quat_y,
   input  logic signed [15:0] req_quat_z,
   input  logic signed [15:0] req_scale_x,
   input  logic signed [15:0] req_scale_y,
   input  logic signed [15:0] req_scale_z,

   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_m00,
   output logic signed [31:0] rsp_m01,
   output logic signed [31:0] rsp_m02,
   output logic signed [31:0] rsp_m10,
   output logic signed [31:0] rsp_m11,
   output logic signed [31:0] rsp_m12,
   output logic signed [31:0] rsp_m20,
   output logic signed [31:0] rsp_m21,
   output logic signed [31:0] rsp_m22,
   output logic signed [31:0] rsp_trans_x,
   output logic signed [31:0] rsp_trans_y,
   output logic signed [31:0] rsp_trans_z
);

   localparam int unsigned Depth = 4;  // register stages request to response

   qtrs_pkg::req_type    req_data;
   qtrs_pkg::stage1_type s1_data;
   qtrs_pkg::stage2_type s2_data;
   qtrs_pkg::rsp_type    rsp_data;
   logic                 s1_valid;
   logic                 s1_ready;
   logic                 s2_valid;
   logic                 s2_ready;

   // request bundle
   always_comb begin
      req_data.pos.x   = req_pos_x;
      req_data.pos.y   = req_pos_y;
      req_data.pos.z   = req_pos_z;
      req_data.quat.w  = req_quat_w;
      req_data.quat.x  = req_quat_x;
      req_data.quat.y  = req_quat_y;
      req_data.quat.z  = req_quat_z;
      req_data.scale.x = req_scale_x;
      req_data.scale.y = req_scale_y;
      req_data.scale.z = req_scale_z;
   end

   // stage 1: quaternion products
   qtrs_prod u_prod (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_data),
      .out_valid (s1_valid),
      .out_ready (s1_ready),
      .out_data  (s1_data)
   );

   // stage 2: rotation terms
   qtrs_term u_term (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_ready  (s1_ready),
      .in_data   (s1_data),
      .out_valid (s2_valid),
      .out_ready (s2_ready),
      .out_data  (s2_data)
   );

   // stages 3 and 4: scale multiply, truncate, output register
   qtrs_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid),
      .in_ready  (s2_ready),
      .in_data   (s2_data),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

   assign rsp_m00     = rsp_data.mat.m00;
   assign rsp_m01     = rsp_data.mat.m01;
   assign rsp_m02     = rsp_data.mat.m02;
   assign rsp_m10     = rsp_data.mat.m10;
   assign rsp_m11     = rsp_data.mat.m11;
   assign rsp_m12     = rsp_data.mat.m12;
   assign rsp_m20     = rsp_data.mat.m20;
   assign rsp_m21     = rsp_data.mat.m21;
   assign rsp_m22     = rsp_data.mat.m22;
   assign rsp_trans_x = rsp_data.pos.x;
   assign rsp_trans_y = rsp_data.pos.y;
   assign rsp_trans_z = rsp_data.pos.z;

   // requests in flight, for the checks below
   logic [$clog2(Depth+1)-1:0] flight_ff;
   logic [$clog2(Depth+1)-1:0] flight_in;
   logic                       req_take;
   logic                       rsp_take;

   assign req_take = req_valid && req_ready;
   assign rsp_take = rsp_valid && rsp_ready;

   always_comb begin
      flight_in = flight_ff;
      if (req_take && !rsp_take) begin
         flight_in = flight_ff + 1'b1;
      end else if (rsp_take && !req_take) begin
         flight_in = flight_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flight_ff <= '0;
      end else begin
         flight_ff <= flight_in;
      end
   end

   a_flight_bound: assert property (@(posedge clock) disable iff (reset)
      flight_ff <= ($clog2(Depth+1))'(Depth))
      else $error("more requests in flight than pipeline stages");

   a_empty_no_rsp: assert property (@(posedge clock) disable iff (reset)
      flight_ff == '0 |-> !rsp_valid)
      else $error("response presented with pipeline empty");

   a_ready_only_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready && flight_ff == ($clog2(Depth+1))'(Depth)))
      else $error("request refused while pipeline has room");

   a_no_rsp_from_nothing: assert property (@(posedge clock) disable iff (reset)
      flight_ff == '0 && !req_take |=> !rsp_take)
      else $error("response taken with no request outstanding");

endmodule

[dv/quaternion_trs_matrix_top_tb.sv]
// quaternion_trs_matrix_top_tb: self-checking bench for the quaternion TRS matrix block.
// Drives requests and responses over valid/ready and predicts every matrix in fixed point.
// Depends on qtrs_pkg and quaternion_trs_matrix_top.

// Holds the predicted matrices in request order and checks each response against them.
class transform_scoreboard;

   localparam longint EntryMax = 64'sd2147483647;
   localparam longint EntryMin = -64'sd2147483648;

   qtrs_pkg::rsp_type pending_transforms[$];
   int mismatches;

   function new();
      mismatches = 0;
   endfunction

   // term in Q2.30 times Q8.8 scale, floored to Q16.16 and clamped
   function automatic logic signed [31:0] scale_term(input longint term, input longint s);
      longint p;
      p = (term * s) >>> qtrs_pkg::FracDrop;
      if (p > EntryMax) p = EntryMax;
      if (p < EntryMin) p = EntryMin;
      return p[31:0];
   endfunction

   function automatic qtrs_pkg::rsp_type predict_transform(input qtrs_pkg::req_type r);
      qtrs_pkg::rsp_type m;
      longint qw, qx, qy, qz, sx, sy, sz, one;
      longint xx, yy, zz, xy, xz, yz, wx, wy, wz;
      qw  = $signed(r.quat.w);
      qx  = $signed(r.quat.x);
      qy  = $signed(r.quat.y);
      qz  = $signed(r.quat.z);
      sx  = $signed(r.scale.x);
      sy  = $signed(r.scale.y);
      sz  = $signed(r.scale.z);
      one = longint'(1) <<< 30;
      xx = qx * qx;  yy = qy * qy;  zz = qz * qz;
      xy = qx * qy;  xz = qx * qz;  yz = qy * qz;
      wx = qw * qx;  wy = qw * qy;  wz = qw * qz;
      m.mat.m00 = scale_term(one - 2 * (yy + zz), sx);
      m.mat.m01 = scale_term(2 * (xy + wz), sx);
      m.mat.m02 = scale_term(2 * (xz - wy), sx);
      m.mat.m10 = scale_term(2 * (xy - wz), sy);
      m.mat.m11 = scale_term(one - 2 * (xx + zz), sy);
      m.mat.m12 = scale_term(2 * (yz + wx), sy);
      m.mat.m20 = scale_term(2 * (xz + wy), sz);
      m.mat.m21 = scale_term(2 * (yz - wx), sz);
      m.mat.m22 = scale_term(one - 2 * (xx + yy), sz);
      m.pos     = r.pos;
      return m;
   endfunction

   function void note_request(input qtrs_pkg::req_type r);
      pending_transforms.push_back(predict_transform(r));
   endfunction

   function int pending();
      return pending_transforms.size();
   endfunction

   // one line per mismatch, each one counted
   task report_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("mismatch %s: got %h want %h", what, got, want);
      mismatches++;
   endtask

   task compare_entry(input string what, input logic [31:0] got, input logic [31:0] want);
      if (got !== want) report_mismatch(what, got, want);
   endtask

   task check_response(input qtrs_pkg::rsp_type got);
      qtrs_pkg::rsp_type want;
      if (pending_transforms.size() == 0) begin
         report_mismatch("unexpected response", got.mat.m00, 32'h0);
         return;
      end
      want = pending_transforms.pop_front();
      compare_entry("m00", got.mat.m00, want.mat.m00);
      compare_entry("m01", got.mat.m01, want.mat.m01);
      compare_entry("m02", got.mat.m02, want.mat.m02);
      compare_entry("m10", got.mat.m10, want.mat.m10);
      compare_entry("m11", got.mat.m11, want.mat.m11);
      compare_entry("m12", got.mat.m12, want.mat.m12);
      compare_entry("m20", got.mat.m20, want.mat.m20);
      compare_entry("m21", got.mat.m21, want.mat.m21);
      compare_entry("m22", got.mat.m22, want.mat.m22);
      compare_entry("trans_x", got.pos.x, want.pos.x);
      compare_entry("trans_y", got.pos.y, want.pos.y);
      compare_entry("trans_z", got.pos.z, want.pos.z);
   endtask

endclass

module quaternion_trs_matrix_top_tb;

   localparam int LimitCycles = 200000;
   localparam int StallCycles = 64;    // long receiver hold-off, well past pipeline depth
   localparam int DrainCycles = 12;    // allow a margin at the end

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              rsp_ready = 1'b0;
   qtrs_pkg::req_type offer = '0;

   logic              req_ready;
   logic              rsp_valid;
   qtrs_pkg::rsp_type observed;

   // idle percentages for each side, changed per phase by the stimulus
   int send_idle_pct = 33;
   int recv_idle_pct = 47;
   bit stall_request = 1'b0;
   int cycle_count = 0;

   transform_scoreboard sb;

   quaternion_trs_matrix_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_pos_x  (offer.pos.x),
      .req_pos_y  (offer.pos.y),
      .req_pos_z  (offer.pos.z),
      .req_quat_w (offer.quat.w),
      .req_quat_x (offer.quat.x),
      .req_quat_y (offer.quat.y),
      .req_quat_z (offer.quat.z),
      .req_scale_x(offer.scale.x),
      .req_scale_y(offer.scale.y),
      .req_scale_z(offer.scale.z),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_m00    (observed.mat.m00),
      .rsp_m01    (observed.mat.m01),
      .rsp_m02    (observed.mat.m02),
      .rsp_m10    (observed.mat.m10),
      .rsp_m11    (observed.mat.m11),
      .rsp_m12    (observed.mat.m12),
      .rsp_m20    (observed.mat.m20),
      .rsp_m21    (observed.mat.m21),
      .rsp_m22    (observed.mat.m22),
      .rsp_trans_x(observed.pos.x),
      .rsp_trans_y(observed.pos.y),
      .rsp_trans_z(observed.pos.z)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      sb = new();
   end

   // Watchdog: a hung handshake or a lost response ends the run here.
   initial begin : watchdog
      while (cycle_count < LimitCycles) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL");
      $finish;
   end

   // Response monitor: outputs are sampled at the rising edge, ready was set
   // at the falling edge before it, so the handshake is settled here.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_response(observed);
   end

   // Receiver: random back-pressure, plus a long hold-off when asked for.
   // The hold-off is counted here so the sender carries on regardless and
   // the pipeline fills up until req_ready drops.
   initial begin : receiver
      int k;
      forever begin
         @(negedge clock);
         if (stall_request) begin
            stall_request = 1'b0;
            rsp_ready <= 1'b0;
            for (k = 1; k < StallCycles; k++) @(negedge clock);
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Field values biased towards the corners now and then.
   function automatic logic [15:0] pick16();
      case ($urandom_range(9))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'h0000;
         3: return 16'hffff;
         default: return 16'($urandom());
      endcase
   endfunction

   function automatic logic [31:0] pick32();
      case ($urandom_range(9))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'h0000_0000;
         default: return $urandom();
      endcase
   endfunction

   function automatic qtrs_pkg::req_type random_request();
      qtrs_pkg::req_type r;
      r.pos.x   = pick32();
      r.pos.y   = pick32();
      r.pos.z   = pick32();
      r.quat.w  = pick16();
      r.quat.x  = pick16();
      r.quat.y  = pick16();
      r.quat.z  = pick16();
      // a share of plausible scales near 1.0 alongside the full range
      if ($urandom_range(3) == 0) begin
         r.scale.x = 16'sd256 + $signed(16'($urandom_range(512))) - 16'sd256;
         r.scale.y = 16'sd256 + $signed(16'($urandom_range(512))) - 16'sd256;
         r.scale.z = 16'sd256 + $signed(16'($urandom_range(512))) - 16'sd256;
      end else begin
         r.scale.x = pick16();
         r.scale.y = pick16();
         r.scale.z = pick16();
      end
      return r;
   endfunction

   function automatic qtrs_pkg::req_type make_request(
      input logic [31:0] px, input logic [31:0] py, input logic [31:0] pz,
      input logic [15:0] qw, input logic [15:0] qx, input logic [15:0] qy,
      input logic [15:0] qz, input logic [15:0] sx, input logic [15:0] sy,
      input logic [15:0] sz);
      qtrs_pkg::req_type r;
      r.pos.x   = px;  r.pos.y   = py;  r.pos.z   = pz;
      r.quat.w  = qw;  r.quat.x  = qx;  r.quat.y  = qy;  r.quat.z = qz;
      r.scale.x = sx;  r.scale.y = sy;  r.scale.z = sz;
      return r;
   endfunction

   // Offer one request from a falling edge, hold it until taken, then idle at
   // random with valid low. Valid is left high when the next request follows
   // straight on, so it is never lowered and raised in the same step.
   task automatic send_request(input qtrs_pkg::req_type r);
      offer     <= r;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      sb.note_request(r);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         offer     <= random_request();   // noise while idle, must be ignored
         @(negedge clock);
      end
   endtask

   // Sender pause: drop valid and wait until every predicted matrix has come.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_random(input int count);
      int n;
      for (n = 0; n < count; n++) send_request(random_request());
   endtask

   initial begin : stimulus
      int saved_idle;

      // Synchronous reset, held from time zero and released on a falling edge.
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed requests: identity, extremes of every field, non-unit and
      // -1.0 components, mirrored columns and alternating bit patterns.
      send_request(make_request(32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
                                16'h7fff, 16'h0000, 16'h0000, 16'h0000,
                                16'h0100, 16'h0100, 16'h0100));
      send_request(make_request(32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0, 16'h0,
                                16'h0, 16'h0, 16'h0));
      send_request(make_request(32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff,
                                16'h8000, 16'h8000, 16'h8000, 16'h8000,
                                16'h7fff, 16'h7fff, 16'h7fff));
      send_request(make_request(32'h8000_0000, 32'h7fff_ffff, 32'h0,
                                16'h8000, 16'h8000, 16'h8000, 16'h8000,
                                16'h8000, 16'h8000, 16'h8000));
      send_request(make_request(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                                16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
                                16'h8000, 16'h8000, 16'h8000));
      send_request(make_request(32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555,
                                16'h5555, 16'haaaa, 16'h5555, 16'haaaa,
                                16'h5555, 16'haaaa, 16'h5555));
      send_request(make_request(32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa,
                                16'haaaa, 16'h5555, 16'haaaa, 16'h5555,
                                16'haaaa, 16'h5555, 16'haaaa));
      // -1.0 in one component at a time, rest zero
      send_request(make_request(32'h1, 32'h2, 32'h3, 16'h8000, 16'h0, 16'h0, 16'h0,
                                16'h0100, 16'h0100, 16'h0100));
      send_request(make_request(32'h1, 32'h2, 32'h3, 16'h0, 16'h8000, 16'h0, 16'h0,
                                16'h0100, 16'h0100, 16'h0100));
      send_request(make_request(32'h1, 32'h2, 32'h3, 16'h0, 16'h0, 16'h8000, 16'h0,
                                16'h0100, 16'h0100, 16'h0100));
      send_request(make_request(32'h1, 32'h2, 32'h3, 16'h0, 16'h0, 16'h0, 16'h8000,
                                16'h0100, 16'h0100, 16'h0100));
      // 90 degrees about z, unit length
      send_request(make_request(32'h0, 32'h0, 32'h0, 16'h5a82, 16'h0, 16'h0, 16'h5a82,
                                16'h0200, 16'h0080, 16'h0100));
      // negative scale mirrors column 0, then columns 1 and 2 together
      send_request(make_request(32'h10, 32'h20, 32'h30, 16'h7fff, 16'h0, 16'h0, 16'h0,
                                16'hff00, 16'h0100, 16'h0100));
      send_request(make_request(32'h10, 32'h20, 32'h30, 16'h4000, 16'h4000, 16'h4000,
                                16'h4000, 16'h0100, 16'hff00, 16'hff00));
      // non-unit quaternion: small and oversized
      send_request(make_request(32'h0, 32'h0, 32'h0, 16'h0100, 16'h0200, 16'hfe00,
                                16'h0080, 16'h7fff, 16'h8000, 16'h0001));
      send_request(make_request(32'h0, 32'h0, 32'h0, 16'h7fff, 16'h7fff, 16'h8000,
                                16'h7fff, 16'h0001, 16'hffff, 16'h8000));
      // smallest scales and one-lsb quaternion parts
      send_request(make_request(32'h0000_0001, 32'hffff_fffe, 32'h8000_0001,
                                16'h0001, 16'hffff, 16'h0001, 16'hffff,
                                16'h0001, 16'hffff, 16'h0001));
      send_request(make_request(32'h7fff_0000, 32'h8000_ffff, 32'h0000_ffff,
                                16'hffff, 16'h0001, 16'hffff, 16'h0001,
                                16'hffff, 16'h0001, 16'hffff));
      wait_for_drain();

      // Phase one: sender idles a third of the time, receiver nearly half.
      send_idle_pct = 33;
      recv_idle_pct = 47;
      send_random(220);

      // Long receiver hold-off while requests keep coming back to back, so
      // all stages fill and req_ready has to drop. Valid is dropped first so
      // the last request is not offered again; the hold-off is asked for just
      // after a rising edge so the receiver picks it up at the next falling edge.
      saved_idle    = send_idle_pct;
      send_idle_pct = 0;
      req_valid    <= 1'b0;
      @(posedge clock);
      stall_request = 1'b1;
      @(negedge clock);
      send_random(30);
      send_idle_pct = saved_idle;
      send_random(230);

      // Phase two: the other way round, with a full drain half way.
      send_idle_pct = 47;
      recv_idle_pct = 33;
      send_random(240);
      wait_for_drain();
      send_random(240);

      // Phase three: neither side idles.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_random(490);

      // Wind down: nothing left to predict, then a few cycles for strays.
      wait_for_drain();
      repeat (DrainCycles) @(posedge clock);

      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
